// ===== rtl/core/bptc_pkg.sv =====
// Shared types and constants for the barometric pressure and temperature compensation block.
// Holds the calibration set, the controller-to-datapath command and status records and the
// fixed-point limits. Depends on nothing else.
package bptc_pkg;

   // Port and field widths.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RAW_W      = 24;
   localparam int TEMP_W     = 15;
   localparam int PRES_W     = 20;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   // Calibration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_C1 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_C2 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_C3 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_C4 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_C5 = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_C6 = 3'd5;

   // Temperature constants on the 20-bit working temperature.
   localparam logic signed [19:0] TEMP_KNEE = 20'sd2000;
   localparam logic signed [19:0] TEMP_LOW  = -20'sd5000;
   localparam logic signed [19:0] TEMP_HIGH = 20'sd10000;
   // Cold threshold expressed as an offset from the knee (-1500 - 2000).
   localparam logic signed [17:0] COLD_DIFF = -18'sd3500;
   localparam logic signed [18:0] COLD_BIAS = 19'sd3500;

   // Pressure plausibility window on the 32-bit working pressure.
   localparam logic signed [31:0] PRES_LOW  = 32'sd200000;
   localparam logic signed [31:0] PRES_HIGH = 32'sd840000;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] c1;
      logic [CSR_DATA_W-1:0] c2;
      logic [CSR_DATA_W-1:0] c3;
      logic [CSR_DATA_W-1:0] c4;
      logic [CSR_DATA_W-1:0] c5;
      logic [CSR_DATA_W-1:0] c6;
   } calib_type;

   // Operand pair fed to the shared multiplier.
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_DT_C6,
      MUL_DT_C4,
      MUL_DT_C3,
      MUL_DT_DT,
      MUL_A_A,
      MUL_B_B,
      MUL_D1_LO,
      MUL_D1_HI
   } mul_sel_type;

   // Datapath register update performed in the cycle.
   typedef enum logic [3:0] {
      WB_NONE,
      WB_TEMP,
      WB_OFF,
      WB_SENS,
      WB_T2,
      WB_A2,
      WB_B2,
      WB_CORR,
      WB_APPLY,
      WB_PLO,
      WB_PHI,
      WB_FULL,
      WB_PRES,
      WB_OUT
   } wb_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/bptc_csr.sv =====
// Calibration register file: six 16-bit factory coefficients written through a plain port.
// Depends on bptc_pkg for the register indexes and the calibration record.
module bptc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bptc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bptc_pkg::calib_type              calib
);
   import bptc_pkg::*;

   calib_type calib_ff;

   // Decode the index; writes beyond the sixth register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_C1: begin
               calib_ff.c1 <= csr_wdata;
            end
            CSR_C2: begin
               calib_ff.c2 <= csr_wdata;
            end
            CSR_C3: begin
               calib_ff.c3 <= csr_wdata;
            end
            CSR_C4: begin
               calib_ff.c4 <= csr_wdata;
            end
            CSR_C5: begin
               calib_ff.c5 <= csr_wdata;
            end
            CSR_C6: begin
               calib_ff.c6 <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign calib = calib_ff;

endmodule

// ===== rtl/core/bptc_ctrl.sv =====
// Sequencer for the compensation datapath: walks one request through the multiply schedule.
// Depends on bptc_pkg for the command and status records.
module bptc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bptc_pkg::status_type  status,
   output bptc_pkg::cmd_type     cmd
);
   import bptc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEMP_MUL,
      ST_OFF_MUL,
      ST_SENS_MUL,
      ST_SQ_MUL,
      ST_A_MUL,
      ST_B_MUL,
      ST_B_WB,
      ST_CORR,
      ST_APPLY,
      ST_PLO_MUL,
      ST_PHI_MUL,
      ST_PHI_WB,
      ST_FULL,
      ST_PRES,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   logic      ready_ff;
   logic      req_fire;

   // Command issued while the sequencer sits in a given state.
   function automatic cmd_type cmd_of(input state_type s);
      cmd_type c;
      c.mul_sel = MUL_NONE;
      c.wb_sel  = WB_NONE;
      case (s)
         ST_TEMP_MUL: begin
            c.mul_sel = MUL_DT_C6;
         end
         ST_OFF_MUL: begin
            c.mul_sel = MUL_DT_C4;
            c.wb_sel  = WB_TEMP;
         end
         ST_SENS_MUL: begin
            c.mul_sel = MUL_DT_C3;
            c.wb_sel  = WB_OFF;
         end
         ST_SQ_MUL: begin
            c.mul_sel = MUL_DT_DT;
            c.wb_sel  = WB_SENS;
         end
         ST_A_MUL: begin
            c.mul_sel = MUL_A_A;
            c.wb_sel  = WB_T2;
         end
         ST_B_MUL: begin
            c.mul_sel = MUL_B_B;
            c.wb_sel  = WB_A2;
         end
         ST_B_WB: begin
            c.wb_sel = WB_B2;
         end
         ST_CORR: begin
            c.wb_sel = WB_CORR;
         end
         ST_APPLY: begin
            c.wb_sel = WB_APPLY;
         end
         ST_PLO_MUL: begin
            c.mul_sel = MUL_D1_LO;
         end
         ST_PHI_MUL: begin
            c.mul_sel = MUL_D1_HI;
            c.wb_sel  = WB_PLO;
         end
         ST_PHI_WB: begin
            c.wb_sel = WB_PHI;
         end
         ST_FULL: begin
            c.wb_sel = WB_FULL;
         end
         ST_PRES: begin
            c.wb_sel = WB_PRES;
         end
         ST_OUT: begin
            c.wb_sel = WB_OUT;
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   assign req_fire = req_tvalid & ready_ff;

   // Next state: a fixed walk, holding in the last step until the output register is free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_TEMP_MUL;
         end
         ST_TEMP_MUL: state_in = ST_OFF_MUL;
         ST_OFF_MUL:  state_in = ST_SENS_MUL;
         ST_SENS_MUL: state_in = ST_SQ_MUL;
         ST_SQ_MUL:   state_in = ST_A_MUL;
         ST_A_MUL:    state_in = ST_B_MUL;
         ST_B_MUL:    state_in = ST_B_WB;
         ST_B_WB:     state_in = ST_CORR;
         ST_CORR:     state_in = ST_APPLY;
         ST_APPLY:    state_in = ST_PLO_MUL;
         ST_PLO_MUL:  state_in = ST_PHI_MUL;
         ST_PHI_MUL:  state_in = ST_PHI_WB;
         ST_PHI_WB:   state_in = ST_FULL;
         ST_FULL:     state_in = ST_PRES;
         ST_PRES:     state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State together with the registered command and ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= cmd_of(ST_IDLE);
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_of(state_in);
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;
   assign cmd        = cmd_ff;

   // A request is taken only once until its result has been loaded into the output register.
   a_no_double_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !ready_ff)
      else $error("bptc_ctrl: ready stayed high after a request was taken");

   // The final step holds while the output register is occupied.
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !status.out_free) |=> (state_ff == ST_OUT))
      else $error("bptc_ctrl: left the output step while the result was not taken");

   // No datapath work is commanded while waiting for a request.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (cmd_ff.mul_sel == MUL_NONE && cmd_ff.wb_sel == WB_NONE))
      else $error("bptc_ctrl: command issued while idle");

endmodule

// ===== rtl/core/bptc_dpath.sv =====
// Compensation datapath: one shared 26x26 signed multiplier, working registers, the held
// values and the result register. Depends on bptc_pkg for commands, status and constants.
module bptc_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [bptc_pkg::RAW_W-1:0]        d1_raw,
   input  logic [bptc_pkg::RAW_W-1:0]        d2_raw,
   input  bptc_pkg::calib_type               calib,
   input  bptc_pkg::cmd_type                 cmd,
   output bptc_pkg::status_type              status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [bptc_pkg::TEMP_W-1:0]       held_temp,
   output logic [bptc_pkg::PRES_W-1:0]       held_pres,
   output logic                              temp_taken,
   output logic                              pres_taken
);
   import bptc_pkg::*;

   // Working registers.
   logic [RAW_W-1:0]    d1_ff;
   logic signed [24:0]  dt_ff;
   logic signed [51:0]  prod_ff;
   logic signed [17:0]  tdiff_ff;
   logic signed [39:0]  off_ff;
   logic signed [39:0]  sens_ff;
   logic [16:0]         t2_ff;
   logic [34:0]         a2_ff;
   logic [34:0]         b2_ff;
   logic [39:0]         off2_ff;
   logic [39:0]         sens2_ff;
   logic signed [19:0]  temp_ff;
   logic [44:0]         plo_ff;
   logic [43:0]         phi_ff;
   logic signed [63:0]  full_ff;
   logic signed [31:0]  pres_ff;

   // Result side.
   logic                rsp_valid_ff;
   logic [TEMP_W-1:0]   held_temp_ff;
   logic [PRES_W-1:0]   held_pres_ff;
   logic                temp_taken_ff;
   logic                pres_taken_ff;

   logic signed [25:0]  mul_a;
   logic signed [25:0]  mul_b;
   logic signed [51:0]  prod_in;
   logic signed [18:0]  bdiff;
   logic                knee;
   logic                cold;
   logic [39:0]         a2_w;
   logic [39:0]         b2_w;
   logic [39:0]         a5;
   logic [39:0]         b7;
   logic [39:0]         b11;
   logic signed [19:0]  temp_base;
   logic [42:0]         q_bits;
   logic signed [43:0]  pres_diff;
   logic                t_ok;
   logic                p_ok;
   logic                out_free;
   logic                out_load;

   // Below the knee when TEMP - 2000 is negative; cold below -1500.
   assign knee  = tdiff_ff[17];
   assign cold  = (tdiff_ff < COLD_DIFF);
   assign bdiff = $signed({tdiff_ff[17], tdiff_ff}) + COLD_BIAS;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_DT_C6: begin
            mul_a = {dt_ff[24], dt_ff};
            mul_b = {10'b0, calib.c6};
         end
         MUL_DT_C4: begin
            mul_a = {dt_ff[24], dt_ff};
            mul_b = {10'b0, calib.c4};
         end
         MUL_DT_C3: begin
            mul_a = {dt_ff[24], dt_ff};
            mul_b = {10'b0, calib.c3};
         end
         MUL_DT_DT: begin
            mul_a = {dt_ff[24], dt_ff};
            mul_b = {dt_ff[24], dt_ff};
         end
         MUL_A_A: begin
            mul_a = {{8{tdiff_ff[17]}}, tdiff_ff};
            mul_b = {{8{tdiff_ff[17]}}, tdiff_ff};
         end
         MUL_B_B: begin
            mul_a = {{7{bdiff[18]}}, bdiff};
            mul_b = {{7{bdiff[18]}}, bdiff};
         end
         MUL_D1_LO: begin
            mul_a = {2'b0, d1_ff};
            mul_b = {6'b0, sens_ff[19:0]};
         end
         MUL_D1_HI: begin
            mul_a = {2'b0, d1_ff};
            mul_b = {{6{sens_ff[39]}}, sens_ff[39:20]};
         end
         default: begin
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Second-order correction terms built from shifts and adds.
   assign a2_w = {5'b0, a2_ff};
   assign b2_w = {5'b0, b2_ff};
   assign a5   = (a2_w << 2) + a2_w;
   assign b7   = (b2_w << 3) - b2_w;
   assign b11  = (b2_w << 3) + (b2_w << 1) + b2_w;

   assign temp_base = $signed({{2{tdiff_ff[17]}}, tdiff_ff}) + TEMP_KNEE;

   // Pressure: (D1*SENS >> 21) - OFF, then >> 12, all flooring.
   assign q_bits    = full_ff[63:21];
   assign pres_diff = $signed({q_bits[42], q_bits}) - $signed({{4{off_ff[39]}}, off_ff});

   assign t_ok = (temp_ff > TEMP_LOW) && (temp_ff < TEMP_HIGH);
   assign p_ok = (pres_ff > PRES_LOW) && (pres_ff < PRES_HIGH);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (cmd.wb_sel == WB_OUT) && out_free;

   // Input capture and the temperature difference dT = D2 - C5 * 256.
   always_ff @(posedge clock) begin
      if (load) begin
         d1_ff <= d1_raw;
         dt_ff <= $signed({1'b0, d2_raw}) - $signed({1'b0, calib.c5, 8'b0});
      end
   end

   // Shared multiplier output register.
   always_ff @(posedge clock) begin
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
   end

   // Working register updates, one step per command.
   always_ff @(posedge clock) begin
      case (cmd.wb_sel)
         WB_TEMP: begin
            tdiff_ff <= prod_ff[40:23];
         end
         WB_OFF: begin
            off_ff <= $signed({{6{prod_ff[40]}}, prod_ff[40:7]})
                    + $signed({8'b0, calib.c2, 16'b0});
         end
         WB_SENS: begin
            sens_ff <= $signed({{7{prod_ff[40]}}, prod_ff[40:8]})
                     + $signed({9'b0, calib.c1, 15'b0});
         end
         WB_T2: begin
            t2_ff <= prod_ff[47:31];
         end
         WB_A2: begin
            a2_ff <= prod_ff[34:0];
         end
         WB_B2: begin
            b2_ff <= prod_ff[34:0];
         end
         WB_CORR: begin
            off2_ff  <= (a5 >> 1) + (cold ? b7 : 40'd0);
            sens2_ff <= (a5 >> 2) + (cold ? (b11 >> 1) : 40'd0);
         end
         WB_APPLY: begin
            if (knee) begin
               temp_ff <= temp_base - $signed({3'b0, t2_ff});
               off_ff  <= off_ff - $signed(off2_ff);
               sens_ff <= sens_ff - $signed(sens2_ff);
            end else begin
               temp_ff <= temp_base;
            end
         end
         WB_PLO: begin
            plo_ff <= prod_ff[44:0];
         end
         WB_PHI: begin
            phi_ff <= prod_ff[43:0];
         end
         WB_FULL: begin
            full_ff <= $signed({phi_ff, 20'b0}) + $signed({19'b0, plo_ff});
         end
         WB_PRES: begin
            pres_ff <= pres_diff[43:12];
         end
         default: begin
         end
      endcase
   end

   // Held values and the result register; held copies only move when a result is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_temp_ff <= '0;
         held_pres_ff <= '0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
         if (t_ok) held_temp_ff <= temp_ff[TEMP_W-1:0];
         if (p_ok) held_pres_ff <= pres_ff[PRES_W-1:0];
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Taken flags travel with the result.
   always_ff @(posedge clock) begin
      if (out_load) begin
         temp_taken_ff <= t_ok;
         pres_taken_ff <= p_ok;
      end
   end

   assign status.out_free = out_free;
   assign rsp_tvalid      = rsp_valid_ff;
   assign held_temp       = held_temp_ff;
   assign held_pres       = held_pres_ff;
   assign temp_taken      = temp_taken_ff;
   assign pres_taken      = pres_taken_ff;

   // A result appears only from the output step.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.wb_sel == WB_OUT))
      else $error("bptc_dpath: result raised outside the output step");

   // Held copies change only when a result is loaded.
   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> ($stable(held_temp_ff) && $stable(held_pres_ff)))
      else $error("bptc_dpath: held value changed without a result");

endmodule

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// Barometric pressure and temperature compensation with second-order correction.
// One request at a time: the single shared 26x26 multiplier is stepped through eight products
// plus add steps, and the next request is accepted only after the result register takes the
// current result. A waiting result stalls the final step, and no new request is accepted meanwhile.
// Reset (synchronous, active high) clears calibration, held values and handshake state.
// Depends on bptc_pkg, bptc_csr, bptc_ctrl and bptc_dpath.
module baro_pressure_temp_compensation (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [23:0] pressure_raw_d1, [47:24] temperature_raw_d2
   input  logic [bptc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [14:0] temperature_centi_c, [34:15] pressure_eighth_pa, [39:35] zero
   output logic [bptc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] temperature_taken, [1] pressure_taken
   output logic [bptc_pkg::RSP_USER_W-1:0]  rsp_tuser,
   // Calibration write port.
   input  logic                             csr_we,
   input  logic [bptc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bptc_pkg::*;

   calib_type         calib;
   cmd_type           cmd;
   status_type        status;
   logic              req_fire;
   logic [TEMP_W-1:0] held_temp;
   logic [PRES_W-1:0] held_pres;
   logic              temp_taken;
   logic              pres_taken;

   assign req_fire = req_tvalid & req_tready;

   bptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .calib     (calib)
   );

   bptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bptc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .d1_raw     (req_tdata[RAW_W-1:0]),
      .d2_raw     (req_tdata[2*RAW_W-1:RAW_W]),
      .calib      (calib),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .held_temp  (held_temp),
      .held_pres  (held_pres),
      .temp_taken (temp_taken),
      .pres_taken (pres_taken)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {{(RSP_DATA_W - TEMP_W - PRES_W){1'b0}}, held_pres, held_temp};
   assign rsp_tuser = {pres_taken, temp_taken};

endmodule

// ===== tb/bptc_compensation_check.sv =====
`timescale 1ns / 100ps
// Result checker for the barometric compensation block: follows the calibration port and
// both streams, predicts every compensated reading and compares it with the block's result.
// Depends on bptc_pkg for the port widths, the calibration record and the register indexes.
module bptc_compensation_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [bptc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [bptc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [bptc_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                             csr_we,
   input  logic [bptc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bptc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               readings_owed
);
   import bptc_pkg::*;

   // Limits of the compensation, held as plain integers for the prediction.
   localparam longint KNEE_CENTI  = 2000;
   localparam longint COLD_CENTI  = -1500;
   localparam longint T_FLOOR     = -5000;
   localparam longint T_CEILING   = 10000;
   localparam longint P_FLOOR     = 200000;
   localparam longint P_CEILING   = 840000;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic [PRES_W-1:0]        pressure;
      logic                     temp_taken;
      logic                     pres_taken;
   } reading_type;

   calib_type                cal;
   logic signed [TEMP_W-1:0] held_temperature;
   logic [PRES_W-1:0]        held_pressure;
   reading_type              readings_due[$];
   int                       errors;

   // Works out the held reading that follows one raw pressure and temperature pair.
   function automatic reading_type compensate(input logic [RAW_W-1:0] d1,
                                              input logic [RAW_W-1:0] d2);
      longint      dt, temp, off, sens, pres, t2, a, b, off2, sens2;
      reading_type r;
      dt   = longint'(d2) - (longint'(cal.c5) << 8);
      off  = (longint'(cal.c2) << 16) + ((dt * longint'(cal.c4)) >>> 7);
      sens = (longint'(cal.c1) << 15) + ((dt * longint'(cal.c3)) >>> 8);
      temp = KNEE_CENTI + ((dt * longint'(cal.c6)) >>> 23);
      // Second-order correction below the knee, with the extra cold term further down.
      if (temp < KNEE_CENTI) begin
         t2    = (dt * dt) >>> 31;
         a     = temp - KNEE_CENTI;
         off2  = (5 * a * a) >>> 1;
         sens2 = (5 * a * a) >>> 2;
         if (temp < COLD_CENTI) begin
            b     = temp - COLD_CENTI;
            off2  = off2 + 7 * b * b;
            sens2 = sens2 + ((11 * b * b) >>> 1);
         end
         temp = temp - t2;
         off  = off - off2;
         sens = sens - sens2;
      end
      pres = (((longint'(d1) * sens) >>> 21) - off) >>> 12;
      r.temp_taken  = (temp > T_FLOOR) && (temp < T_CEILING);
      r.pres_taken  = (pres > P_FLOOR) && (pres < P_CEILING);
      r.temperature = r.temp_taken ? temp[TEMP_W-1:0] : held_temperature;
      r.pressure    = r.pres_taken ? pres[PRES_W-1:0] : held_pressure;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
   endtask

   // Compares results, predicts new requests and follows calibration writes, edge by edge.
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         cal              = '0;
         held_temperature = '0;
         held_pressure    = '0;
         readings_due.delete();
         errors           = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               report_mismatch("result with no request waiting");
            end else begin
               want = readings_due.pop_front();
               if (rsp_tdata[TEMP_W-1:0] !== want.temperature)
                  report_mismatch($sformatf("temperature got %0d want %0d",
                     $signed(rsp_tdata[TEMP_W-1:0]), want.temperature));
               if (rsp_tdata[TEMP_W+PRES_W-1:TEMP_W] !== want.pressure)
                  report_mismatch($sformatf("pressure got %0d want %0d",
                     rsp_tdata[TEMP_W+PRES_W-1:TEMP_W], want.pressure));
               if (rsp_tdata[RSP_DATA_W-1:TEMP_W+PRES_W] !== '0)
                  report_mismatch($sformatf("padding bits got %b",
                     rsp_tdata[RSP_DATA_W-1:TEMP_W+PRES_W]));
               if (rsp_tuser[0] !== want.temp_taken)
                  report_mismatch($sformatf("temperature flag got %b want %b",
                     rsp_tuser[0], want.temp_taken));
               if (rsp_tuser[1] !== want.pres_taken)
                  report_mismatch($sformatf("pressure flag got %b want %b",
                     rsp_tuser[1], want.pres_taken));
            end
         end
         if (req_tvalid && req_tready) begin
            want = compensate(req_tdata[RAW_W-1:0], req_tdata[2*RAW_W-1:RAW_W]);
            held_temperature = want.temperature;
            held_pressure    = want.pressure;
            readings_due.push_back(want);
         end
         // Writes to indexes past the six coefficients leave the calibration alone.
         if (csr_we) begin
            case (csr_addr)
               CSR_C1: cal.c1 = csr_wdata;
               CSR_C2: cal.c2 = csr_wdata;
               CSR_C3: cal.c3 = csr_wdata;
               CSR_C4: cal.c4 = csr_wdata;
               CSR_C5: cal.c5 = csr_wdata;
               CSR_C6: cal.c6 = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatches    <= errors;
      readings_owed <= readings_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the barometric compensation block: clock, reset, calibration
// phases and random request and result traffic, with the verdict at the end.
// Depends on bptc_pkg, the block itself and bptc_compensation_check.
module tb_top;
   import bptc_pkg::*;

   // Indexes past the last coefficient; writes there must be ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_B = 3'd7;
   localparam logic [RAW_W-1:0]      RAW_FULL    = 24'hFFFFFF;
   // A representative factory calibration and its reference temperature reading.
   localparam calib_type TYPICAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                     c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};
   localparam logic [RAW_W-1:0] TYP_REF = 24'd8566784;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;
   logic                    quiet      = 1'b0;
   int                      rsp_wait   = 0;
   int                      mismatches;
   int                      readings_owed;

   baro_pressure_temp_compensation uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   bptc_compensation_check comp_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .readings_owed(readings_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side stalls for a random number of cycles after each result it takes.
   always @(posedge clock) begin
      int pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         pause = quiet ? 0 : $urandom_range(0, 7);
         rsp_wait   <= pause;
         rsp_tready <= (pause == 0);
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait   <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // Offers one request after a random gap and holds it until it is taken.
   task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {d2, d1};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops the request line, waits for every result and lets the pipeline drain.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (readings_owed != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Loads all six coefficients and throws stray writes at the unused indexes.
   task automatic program_calib(input calib_type c);
      write_csr(CSR_C1, c.c1);
      write_csr(CSR_C2, c.c2);
      write_csr(CSR_SPARE_A, 16'($urandom()));
      write_csr(CSR_C3, c.c3);
      write_csr(CSR_C4, c.c4);
      write_csr(CSR_C5, c.c5);
      write_csr(CSR_SPARE_B, 16'($urandom()));
      write_csr(CSR_C6, c.c6);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] jitter(input logic [CSR_DATA_W-1:0] v);
      return v + 16'($urandom_range(0, 4000)) - 16'd2000;
   endfunction

   // Temperature reading spread around the reference so that most land cold to hot.
   function automatic logic [RAW_W-1:0] temp_raw_near(input logic [CSR_DATA_W-1:0] c5);
      int v;
      v = int'(c5) * 256 + $urandom_range(0, 5000000) - 2500000;
      if (v < 0) v = 0;
      if (v > int'(RAW_FULL)) v = int'(RAW_FULL);
      return v[RAW_W-1:0];
   endfunction

   initial begin
      calib_type        cal;
      logic [RAW_W-1:0] d1, d2;
      int               phase, n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Calibration never written: every coefficient reads as zero.
      send_sample('0, '0);
      send_sample(RAW_FULL, RAW_FULL);
      send_sample(24'd12345, '0);
      wait_idle();

      // Typical calibration: knee, mild and deep cold, both edges of both windows.
      program_calib(TYPICAL);
      send_sample(24'd9085466, 24'd8569150);
      send_sample(24'd9085466, TYP_REF);
      send_sample(24'd9085466, TYP_REF - 24'd1);
      send_sample(24'd8000000, TYP_REF - 24'd600000);
      send_sample(24'd8000000, TYP_REF - 24'd1800000);
      send_sample(24'd8000000, TYP_REF - 24'd2300000);
      send_sample(24'd8000000, TYP_REF + 24'd2500000);
      send_sample(24'd3000000, 24'd8569150);
      send_sample(24'd12000000, 24'd8569150);
      send_sample('0, 24'd8569150);
      send_sample(RAW_FULL, 24'd8569150);
      send_sample(24'd9085466, '0);
      send_sample(24'd9085466, RAW_FULL);
      wait_idle();

      // Largest coefficients with the raw extremes.
      program_calib('1);
      send_sample('0, '0);
      send_sample(RAW_FULL, RAW_FULL);
      send_sample('0, RAW_FULL);
      send_sample(RAW_FULL, '0);
      wait_idle();

      // Coefficients written back to zero.
      program_calib('0);
      send_sample(RAW_FULL, '0);
      send_sample('0, RAW_FULL);

      // Random phases: mostly plausible readings on a near-typical calibration.
      for (phase = 0; phase < 9; phase++) begin
         wait_idle();
         quiet <= ($urandom_range(0, 3) == 0);
         if (phase % 3 == 1) begin
            cal.c1 = 16'($urandom()); cal.c2 = 16'($urandom()); cal.c3 = 16'($urandom());
            cal.c4 = 16'($urandom()); cal.c5 = 16'($urandom()); cal.c6 = 16'($urandom());
         end else begin
            cal.c1 = jitter(TYPICAL.c1); cal.c2 = jitter(TYPICAL.c2);
            cal.c3 = jitter(TYPICAL.c3); cal.c4 = jitter(TYPICAL.c4);
            cal.c5 = jitter(TYPICAL.c5); cal.c6 = jitter(TYPICAL.c6);
         end
         program_calib(cal);
         for (n = 0; n < 50; n++) begin
            if ($urandom_range(0, 4) != 0) begin
               d1 = 24'($urandom_range(4000000, 10000000));
               d2 = temp_raw_near(cal.c5);
            end else begin
               d1 = 24'($urandom());
               d2 = 24'($urandom());
            end
            send_sample(d1, d2);
         end
      end

      wait_idle();
      if (mismatches == 0 && readings_owed == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bptc_pkg.sv
rtl/core/bptc_csr.sv
rtl/core/bptc_ctrl.sv
rtl/core/bptc_dpath.sv
rtl/core/baro_pressure_temp_compensation.sv
tb/bptc_compensation_check.sv
tb/tb_top.sv
